@@ rtl/core/assert_macros.svh @@
// assertion macros used by the checker file
// no dependencies; guarded against double inclusion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, switched off during reset
`define FPTD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fptd assertion failed");

// next-cycle implication, switched off during reset
`define FPTD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fptd assertion failed");

`endif

@@ rtl/core/fptd_pkg.sv @@
// shared widths, codes, types and constant functions of the fixed-point converter
// no dependencies; used by the top level and the checker
package fptd_pkg;

   localparam int WORD_W     = 32;
   localparam int CFG_W      = 6;
   localparam int SUM_W      = 30;   // holds 10^9
   localparam int DIGIT_W    = 4;
   localparam int PACKED_W   = 36;
   localparam int DIGIT_MAX  = 9;
   localparam int DATA_W     = 32;
   localparam int CSR_ADDR_W = 3;

   localparam int FRACTION_DIGITS_DEFAULT = 9;

   // fraction sum tree: four groups of eight weights
   localparam int GROUPS      = 4;
   localparam int GROUP_TERMS = 8;

   localparam logic [CFG_W-1:0] WORD_LENGTH_RESET     = 6'd16;
   localparam logic [CFG_W-1:0] FRACTION_LENGTH_RESET = 6'd14;

   typedef enum logic [0:0] {
      OP_UNSIGNED = 1'b0,
      OP_SIGNED   = 1'b1
   } op_type;

   typedef enum logic [0:0] {
      CSR_WORD_LENGTH     = 1'b0,
      CSR_FRACTION_LENGTH = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic              err;
      logic              neg;
      logic [WORD_W-1:0] int_part;
   } side_type;

   function automatic logic [SUM_W-1:0] pow10(input int n);
      logic [SUM_W-1:0] p;
      p = SUM_W'(1);
      for (int i = 0; i < n; i++) begin
         p = SUM_W'(p * 10);
      end
      return p;
   endfunction

   // truncated weight of fraction bit k
   function automatic logic [SUM_W-1:0] weight(input int digits, input int k);
      return pow10(digits) >> k;
   endfunction

endpackage

@@ rtl/core/fixed_point_to_decimal.sv @@
// fixed-point to decimal converter: sign, integer magnitude and packed bcd fraction
// depends on fptd_pkg
//
//   channel   direction  handshake              payload
//   req       in         req_valid / req_stall  req_operation, req_word
//   rsp       out        rsp_valid / rsp_stall  rsp_status, rsp_negative,
//                                               rsp_integer_part, rsp_fraction_digits
//   csr       in/out     psel/penable/pready    paddr, pwdata, pwrite, prdata
//
// one request per cycle while req_stall is low; each request passes sign, split,
//   partial sums and final sum, then one register stage per extracted decimal digit
// reset clears the pipeline valid bits and loads word length 16, fraction length 14
// each stage holds while the stage after it is full and held, so empty stages
//   close up under an output stall and nothing is dropped or repeated
// req_stall is low whenever rsp_valid is low
module fixed_point_to_decimal #(
   parameter int FRACTION_DIGITS = fptd_pkg::FRACTION_DIGITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_operation,
   input  logic [fptd_pkg::WORD_W-1:0]         req_word,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_status,
   output logic                                rsp_negative,
   output logic [fptd_pkg::WORD_W-1:0]         rsp_integer_part,
   output logic [fptd_pkg::PACKED_W-1:0]       rsp_fraction_digits,
   // configuration port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [fptd_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [fptd_pkg::DATA_W-1:0]         pwdata,
   output logic [fptd_pkg::DATA_W-1:0]         prdata,
   output logic                                pready
);

   localparam int WORD_W   = fptd_pkg::WORD_W;
   localparam int CFG_W    = fptd_pkg::CFG_W;
   localparam int SUM_W    = fptd_pkg::SUM_W;
   localparam int DIGIT_W  = fptd_pkg::DIGIT_W;
   localparam int PACKED_W = fptd_pkg::PACKED_W;
   localparam int GROUPS   = fptd_pkg::GROUPS;
   localparam int TERMS    = fptd_pkg::GROUP_TERMS;

   // stage map: 0 sign, 1 split, 2 partial sums, 3 final sum, then one per digit
   localparam int FIRST_DIGIT_STAGE = 4;
   localparam int N_STAGES          = FIRST_DIGIT_STAGE + FRACTION_DIGITS;

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   logic [CFG_W-1:0]        wl_ff;
   logic [CFG_W-1:0]        fl_ff;
   logic                    csr_write;
   fptd_pkg::csr_index_type csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = fptd_pkg::csr_index_type'(paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         wl_ff <= fptd_pkg::WORD_LENGTH_RESET;
         fl_ff <= fptd_pkg::FRACTION_LENGTH_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            fptd_pkg::CSR_WORD_LENGTH:     wl_ff <= pwdata[CFG_W-1:0];
            fptd_pkg::CSR_FRACTION_LENGTH: fl_ff <= pwdata[CFG_W-1:0];
            default:                       wl_ff <= wl_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         fptd_pkg::CSR_WORD_LENGTH:     prdata = fptd_pkg::DATA_W'(wl_ff);
         fptd_pkg::CSR_FRACTION_LENGTH: prdata = fptd_pkg::DATA_W'(fl_ff);
         default:                       prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // pipeline flow control: a stage loads when it is empty or moving on
   // ------------------------------------------------------------------
   logic [N_STAGES-1:0] valid_ff;
   logic [N_STAGES-1:0] rdy;

   always_comb begin
      rdy[N_STAGES-1] = !valid_ff[N_STAGES-1] || !rsp_stall;
      for (int i = N_STAGES - 2; i >= 0; i--) begin
         rdy[i] = !valid_ff[i] || rdy[i+1];
      end
   end

   assign req_stall = !rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (rdy[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int i = 1; i < N_STAGES; i++) begin
            if (rdy[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // stage 0: length check, word mask, sign and two's complement magnitude
   // an invalid configuration forces every result field but the status to zero
   // ------------------------------------------------------------------
   logic              cfg_err;
   logic [WORD_W-1:0] wmask;
   logic [WORD_W-1:0] masked;
   logic [4:0]        sign_pos;
   logic              s0_neg_in;
   logic [WORD_W-1:0] s0_mag_in;
   logic              s0_err_ff;
   logic              s0_neg_ff;
   logic [WORD_W-1:0] s0_mag_ff;

   always_comb begin
      cfg_err  = (wl_ff == '0) || (wl_ff > CFG_W'(WORD_W)) || (fl_ff > wl_ff);
      wmask    = {WORD_W{1'b1}} >> (CFG_W'(WORD_W) - wl_ff);
      masked   = req_word & wmask;
      sign_pos = 5'(wl_ff - CFG_W'(1));
      s0_neg_in = (req_operation == fptd_pkg::OP_SIGNED) && masked[sign_pos];
      s0_mag_in = s0_neg_in ? ((~masked + WORD_W'(1)) & wmask) : masked;
      if (cfg_err) begin
         s0_neg_in = 1'b0;
         s0_mag_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         s0_err_ff <= cfg_err;
         s0_neg_ff <= s0_neg_in;
         s0_mag_ff <= s0_mag_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 1: split at the binary point
   // fraction is left aligned, so fraction bit k sits at index WORD_W-k
   // ------------------------------------------------------------------
   fptd_pkg::side_type s1_side_in;
   logic [WORD_W-1:0]  s1_frac_in;
   fptd_pkg::side_type s1_side_ff;
   logic [WORD_W-1:0]  s1_frac_ff;

   always_comb begin
      s1_side_in.err      = s0_err_ff;
      s1_side_in.neg      = s0_neg_ff;
      s1_side_in.int_part = (fl_ff >= CFG_W'(WORD_W)) ? '0 : (s0_mag_ff >> fl_ff);
      // a shift of the full width leaves nothing when there is no fraction
      s1_frac_in          = s0_mag_ff << (CFG_W'(WORD_W) - fl_ff);
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         s1_side_ff <= s1_side_in;
         s1_frac_ff <= s1_frac_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 2: four partial sums of up to eight weights each
   // the weight of 2^-32 and beyond is dropped
   // ------------------------------------------------------------------
   logic [SUM_W-1:0] s2_psum_in [GROUPS];
   fptd_pkg::side_type s2_side_ff;
   logic [SUM_W-1:0] s2_psum_ff [GROUPS];

   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         s2_psum_in[g] = '0;
         for (int j = 0; j < TERMS; j++) begin
            if ((TERMS * g + j + 1) < WORD_W) begin
               if (s1_frac_ff[WORD_W - (TERMS * g + j + 1)]) begin
                  s2_psum_in[g] = s2_psum_in[g]
                     + fptd_pkg::weight(FRACTION_DIGITS, TERMS * g + j + 1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         s2_side_ff <= s1_side_ff;
         for (int g = 0; g < GROUPS; g++) begin
            s2_psum_ff[g] <= s2_psum_in[g];
         end
      end
   end

   // ------------------------------------------------------------------
   // stage 3: fraction sum, always below 10^FRACTION_DIGITS
   // ------------------------------------------------------------------
   logic [SUM_W-1:0]   s3_sum_in;
   fptd_pkg::side_type s3_side_ff;
   logic [SUM_W-1:0]   s3_sum_ff;

   always_comb begin
      s3_sum_in = '0;
      for (int g = 0; g < GROUPS; g++) begin
         s3_sum_in = s3_sum_in + s2_psum_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         s3_side_ff <= s2_side_ff;
         s3_sum_ff  <= s3_sum_in;
      end
   end

   // ------------------------------------------------------------------
   // digit stages: each finds one decimal digit, most significant first,
   // by comparing the remainder against the nine multiples of its power of ten
   // ------------------------------------------------------------------
   fptd_pkg::side_type dg_side_ff   [FRACTION_DIGITS];
   logic [SUM_W-1:0]   dg_rem_ff    [FRACTION_DIGITS];
   logic [PACKED_W-1:0] dg_packed_ff [FRACTION_DIGITS];

   for (genvar d = 0; d < FRACTION_DIGITS; d++) begin : g_digit
      localparam logic [SUM_W-1:0] DIV = fptd_pkg::pow10(FRACTION_DIGITS - 1 - d);
      localparam int STG = FIRST_DIGIT_STAGE + d;

      fptd_pkg::side_type  side_src;
      logic [SUM_W-1:0]    rem_src;
      logic [PACKED_W-1:0] pk_src;
      logic [DIGIT_W-1:0]  dig;
      logic [SUM_W-1:0]    sub;
      logic [SUM_W-1:0]    rem_in;
      logic [PACKED_W-1:0] pk_in;

      if (d == 0) begin : g_first
         assign side_src = s3_side_ff;
         assign rem_src  = s3_sum_ff;
         assign pk_src   = '0;
      end else begin : g_next
         assign side_src = dg_side_ff[d-1];
         assign rem_src  = dg_rem_ff[d-1];
         assign pk_src   = dg_packed_ff[d-1];
      end

      always_comb begin
         dig = '0;
         sub = '0;
         for (int m = 1; m <= fptd_pkg::DIGIT_MAX; m++) begin
            if (rem_src >= SUM_W'(m * DIV)) begin
               dig = DIGIT_W'(m);
               sub = SUM_W'(m * DIV);
            end
         end
         rem_in = rem_src - sub;
         pk_in  = pk_src;
         pk_in[PACKED_W - 1 - DIGIT_W * d -: DIGIT_W] = dig;
      end

      always_ff @(posedge clock) begin
         if (rdy[STG]) begin
            dg_side_ff[d]   <= side_src;
            dg_rem_ff[d]    <= rem_in;
            dg_packed_ff[d] <= pk_in;
         end
      end
   end

   // ------------------------------------------------------------------
   // result: straight from the last digit stage
   // ------------------------------------------------------------------
   assign rsp_valid           = valid_ff[N_STAGES-1];
   assign rsp_status          = dg_side_ff[FRACTION_DIGITS-1].err;
   assign rsp_negative        = dg_side_ff[FRACTION_DIGITS-1].neg;
   assign rsp_integer_part    = dg_side_ff[FRACTION_DIGITS-1].int_part;
   assign rsp_fraction_digits = dg_packed_ff[FRACTION_DIGITS-1];

endmodule

@@ rtl/core/fptd_checker.sv @@
// port-level checks on the fixed-point converter, bound to the top level
// depends on fptd_pkg and assert_macros.svh
`include "assert_macros.svh"

module fptd_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic                          rsp_status,
   input logic                          rsp_negative,
   input logic [fptd_pkg::WORD_W-1:0]   rsp_integer_part,
   input logic [fptd_pkg::PACKED_W-1:0] rsp_fraction_digits
);

   logic                                              rsp_err;
   logic                                              rsp_clear;
   logic                                              rsp_held;
   logic [fptd_pkg::WORD_W+fptd_pkg::PACKED_W+1:0]    rsp_payload;

   assign rsp_err     = rsp_valid && rsp_status;
   assign rsp_clear   = !rsp_negative && rsp_integer_part == '0 && rsp_fraction_digits == '0;
   assign rsp_held    = rsp_valid && rsp_stall;
   assign rsp_payload = {rsp_status, rsp_negative, rsp_integer_part, rsp_fraction_digits};

   // every nibble is a decimal digit
   function automatic logic all_bcd(input logic [fptd_pkg::PACKED_W-1:0] v);
      logic ok;
      ok = 1'b1;
      for (int i = 0; i < fptd_pkg::PACKED_W / fptd_pkg::DIGIT_W; i++) begin
         if (v[fptd_pkg::DIGIT_W * i +: fptd_pkg::DIGIT_W] > fptd_pkg::DIGIT_MAX) begin
            ok = 1'b0;
         end
      end
      return ok;
   endfunction

   // bad length setting gives zero sign, integer part and fraction
   `FPTD_ASSERT_IMP(a_err_zero, clock, reset, rsp_err, rsp_clear)

   `FPTD_ASSERT_IMP(a_bcd, clock, reset, rsp_valid, all_bcd(rsp_fraction_digits))

   // an empty output stage means the pipe can always move
   `FPTD_ASSERT_IMP(a_drained_ready, clock, reset, !rsp_valid, !req_stall)

   `FPTD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_payload))

endmodule

bind fixed_point_to_decimal fptd_checker u_fptd_checker (.*);
